[design/mflf_pkg.sv]
package mflf_pkg;

  localparam int CHAR_BITS       = 8;
  localparam int LETTER_BITS     = 7;
  localparam int TOP_COUNT_BITS  = 8;
  localparam int LETTER_COUNT    = 26;
  localparam int IDX_BITS        = 5;
  localparam int COUNT_BITS_DEF  = 8;
  localparam int QUEUE_DEPTH_DEF = 4;

  localparam logic [CHAR_BITS-1:0]      LETTER_FIRST   = 8'h61;
  localparam logic [CHAR_BITS-1:0]      LETTER_LAST    = 8'h7A;
  localparam logic [IDX_BITS-1:0]       LAST_IDX       = IDX_BITS'(LETTER_COUNT - 1);
  localparam logic [TOP_COUNT_BITS-1:0] TOP_COUNT_MAX  = '1;

  // One classified character as it travels through the queue
  typedef struct packed {
    logic                is_letter;
    logic [IDX_BITS-1:0] idx;
    logic                last;
  } mflf_item_t;

  // Front to queue
  typedef struct packed {
    logic       push;
    mflf_item_t item;
  } mflf_push_t;

  // Queue to back
  typedef struct packed {
    logic       avail;
    mflf_item_t item;
  } mflf_head_t;

endpackage

[design/mflf_in_if.sv]
interface mflf_in_if;
  import mflf_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [CHAR_BITS-1:0] char_code;
  logic                 end_of_sentence;

  modport source (output valid, output char_code, output end_of_sentence, input ready);
  modport sink   (input valid, input char_code, input end_of_sentence, output ready);
endinterface

[design/mflf_out_if.sv]
interface mflf_out_if;
  import mflf_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [LETTER_BITS-1:0]    top_letter;
  logic [TOP_COUNT_BITS-1:0] top_count;
  logic                      found;
  logic                      last_of_run;

  modport source (output valid, output top_letter, output top_count, output found,
                  output last_of_run, input ready);
  modport sink   (input valid, input top_letter, input top_count, input found,
                  input last_of_run, output ready);
endinterface

[design/mflf_front.sv]
module mflf_front (
  mflf_in_if.sink            in_ch,
  input  logic               full,
  output mflf_pkg::mflf_push_t push_o
);
  import mflf_pkg::*;

  logic                 is_letter;
  logic [CHAR_BITS-1:0] offset;

  assign in_ch.ready = !full;

  always_comb begin
    is_letter = (in_ch.char_code >= LETTER_FIRST) && (in_ch.char_code <= LETTER_LAST);
    offset    = in_ch.char_code - LETTER_FIRST;
    push_o.push           = in_ch.valid && !full;
    push_o.item.is_letter = is_letter;
    // non-letters carry bin zero so the back never reads past the bins
    push_o.item.idx       = is_letter ? offset[IDX_BITS-1:0] : '0;
    push_o.item.last      = in_ch.end_of_sentence;
  end
endmodule

[design/mflf_queue.sv]
module mflf_queue #(
  parameter int DEPTH = mflf_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  mflf_pkg::mflf_push_t push_i,
  input  logic                 pop,
  output logic                 full,
  output mflf_pkg::mflf_head_t head_o
);
  import mflf_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  mflf_item_t    mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign full         = (cnt_r == CW'(DEPTH));
  assign head_o.avail = (cnt_r != '0);
  assign head_o.item  = mem_r[rd_ptr_r];

  always_comb begin
    do_push    = push_i.push && !full;
    do_pop     = pop && head_o.avail;
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    cnt_nxt = cnt_r + CW'(do_push) - CW'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_i.item;
    end
  end
endmodule

[design/mflf_back.sv]
module mflf_back #(
  parameter int COUNT_BITS = mflf_pkg::COUNT_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  mflf_pkg::mflf_head_t head_i,
  output logic                 pop,
  mflf_out_if.source           out_ch
);
  import mflf_pkg::*;

  localparam int EW = (COUNT_BITS > TOP_COUNT_BITS) ? COUNT_BITS : TOP_COUNT_BITS;
  localparam logic [COUNT_BITS-1:0] BIN_LIMIT = '1;

  typedef enum logic [3:0] {
    ST_COUNT = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_FLUSH = 4'b0100,
    ST_NONE  = 4'b1000
  } back_state_t;

  back_state_t state_r, state_nxt;

  logic [COUNT_BITS-1:0] bins_r [LETTER_COUNT];
  logic [COUNT_BITS-1:0] best_r, best_nxt;
  logic [IDX_BITS-1:0]   scan_r, scan_nxt;
  logic                  pend_v_r, pend_v_nxt;
  logic [IDX_BITS-1:0]   pend_idx_r, pend_idx_nxt;

  logic [IDX_BITS-1:0]   rd_idx, wr_idx;
  logic [COUNT_BITS-1:0] rd_data, wr_data, inc_val, best_upd;
  logic                  wr_en, hit;
  logic [EW-1:0]         best_ext;
  logic [TOP_COUNT_BITS-1:0] shown;

  logic                      out_valid_r;
  logic [LETTER_BITS-1:0]    out_letter_r;
  logic [TOP_COUNT_BITS-1:0] out_count_r;
  logic                      out_found_r, out_last_r;
  logic                      can_load, load, ld_found, ld_last;
  logic [LETTER_BITS-1:0]    ld_letter;
  logic [TOP_COUNT_BITS-1:0] ld_count;
  logic [CHAR_BITS-1:0]      pend_char;

  assign can_load = !out_valid_r || out_ch.ready;

  always_comb begin
    best_ext  = EW'(best_r);
    shown     = (best_ext > EW'(TOP_COUNT_MAX)) ? TOP_COUNT_MAX
                                                : best_ext[TOP_COUNT_BITS-1:0];
    pend_char = LETTER_FIRST + CHAR_BITS'(pend_idx_r);
    rd_idx    = (state_r == ST_SCAN) ? scan_r : head_i.item.idx;
    rd_data   = bins_r[rd_idx];
    inc_val   = (rd_data == BIN_LIMIT) ? rd_data : rd_data + 1'b1;
    best_upd  = (head_i.item.is_letter && inc_val > best_r) ? inc_val : best_r;
    hit       = (rd_data == best_r);
  end

  always_comb begin
    state_nxt    = state_r;
    scan_nxt     = scan_r;
    best_nxt     = best_r;
    pend_v_nxt   = pend_v_r;
    pend_idx_nxt = pend_idx_r;
    wr_en        = 1'b0;
    wr_idx       = head_i.item.idx;
    wr_data      = inc_val;
    pop          = 1'b0;
    load         = 1'b0;
    ld_letter    = '0;
    ld_count     = '0;
    ld_found     = 1'b0;
    ld_last      = 1'b0;
    unique case (state_r)
      ST_COUNT: begin
        if (head_i.avail) begin
          pop      = 1'b1;
          wr_en    = head_i.item.is_letter;
          best_nxt = best_upd;
          if (head_i.item.last) begin
            scan_nxt  = '0;
            state_nxt = (best_upd == '0) ? ST_NONE : ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        // hold while an earlier match still needs the output register
        if (!(hit && pend_v_r && !can_load)) begin
          wr_en   = 1'b1;
          wr_idx  = scan_r;
          wr_data = '0;
          if (hit) begin
            if (pend_v_r) begin
              load      = 1'b1;
              ld_letter = pend_char[LETTER_BITS-1:0];
              ld_count  = shown;
              ld_found  = 1'b1;
            end
            pend_v_nxt   = 1'b1;
            pend_idx_nxt = scan_r;
          end
          if (scan_r == LAST_IDX) begin
            state_nxt = ST_FLUSH;
          end else begin
            scan_nxt = scan_r + 1'b1;
          end
        end
      end
      ST_FLUSH: begin
        if (can_load) begin
          load       = 1'b1;
          ld_letter  = pend_char[LETTER_BITS-1:0];
          ld_count   = shown;
          ld_found   = 1'b1;
          ld_last    = 1'b1;
          pend_v_nxt = 1'b0;
          best_nxt   = '0;
          state_nxt  = ST_COUNT;
        end
      end
      ST_NONE: begin
        if (can_load) begin
          load      = 1'b1;
          ld_last   = 1'b1;
          state_nxt = ST_COUNT;
        end
      end
      default: begin
        state_nxt = ST_COUNT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_COUNT;
      best_r      <= '0;
      scan_r      <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < LETTER_COUNT; i++) begin
        bins_r[i] <= '0;
      end
    end else begin
      state_r  <= state_nxt;
      best_r   <= best_nxt;
      scan_r   <= scan_nxt;
      pend_v_r <= pend_v_nxt;
      if (wr_en) begin
        bins_r[wr_idx] <= wr_data;
      end
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    pend_idx_r <= pend_idx_nxt;
    if (load) begin
      out_letter_r <= ld_letter;
      out_count_r  <= ld_count;
      out_found_r  <= ld_found;
      out_last_r   <= ld_last;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.top_letter  = out_letter_r;
  assign out_ch.top_count   = out_count_r;
  assign out_ch.found       = out_found_r;
  assign out_ch.last_of_run = out_last_r;
endmodule

[design/most_frequent_letter_finder.sv]
// Throughput: one character per cycle while the queue has room; at the end of a sentence the
//   back stops draining to scan the bins and flush the final result, longer while the result side stalls.
// Latency: a match is presented in the cycle after the next match is scanned, or after the
//   flush, which also carries the final result of the sentence.
// Reset (rst_n, synchronous, active low): empties the queue and output register,
//   clears all 26 bins and the running maximum.
module most_frequent_letter_finder #(
  parameter int COUNT_BITS  = mflf_pkg::COUNT_BITS_DEF,
  parameter int QUEUE_DEPTH = mflf_pkg::QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  mflf_in_if.sink    in_ch,
  mflf_out_if.source out_ch
);
  import mflf_pkg::*;

  // Front: take one character beat, classify it as a letter bin or ignore,
  // and push it into the queue. Back-pressure comes straight from the queue.
  mflf_push_t push;
  logic       q_full;

  // Back: drain the queue one entry per cycle into the histogram. On the
  // end-of-sentence entry stop draining and scan the bins in alphabetical
  // order, clearing each bin as it is passed. A matching letter is held back
  // one match so that the last one can carry last_of_run.
  mflf_head_t head;
  logic       pop;

  mflf_front u_front (
    .in_ch  (in_ch),
    .full   (q_full),
    .push_o (push)
  );

  mflf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push_i (push),
    .pop    (pop),
    .full   (q_full),
    .head_o (head)
  );

  mflf_back #(
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .head_i (head),
    .pop    (pop),
    .out_ch (out_ch)
  );
endmodule

[dv/tb_most_frequent_letter_finder.sv]
module tb_most_frequent_letter_finder;
  import mflf_pkg::*;

  // Bin width under test; the predictor follows the same value.
  localparam int                  CNT_W     = COUNT_BITS_DEF;
  localparam logic [CNT_W-1:0]    BIN_LIMIT = '1;
  localparam int                  CLK_HALF  = 6;
  // Long enough for the bin scan, the final flush and a little slack.
  localparam int                  TAIL_CYC  = 64;

  // One character waiting for the driver. hold asks the driver to wait until
  // every result owed so far has been collected before offering this beat.
  typedef struct packed {
    logic [CHAR_BITS-1:0] ch;
    logic                 eos;
    logic                 hold;
  } char_beat_t;

  // One most-frequent-letter report as the block should give it.
  typedef struct packed {
    logic [LETTER_BITS-1:0]    letter;
    logic [TOP_COUNT_BITS-1:0] tally;
    logic                      found;
    logic                      last;
  } top_rec_t;

  logic clk;
  logic rst_n;

  mflf_in_if  in_ch ();
  mflf_out_if out_ch ();

  most_frequent_letter_finder #(.COUNT_BITS(CNT_W)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Characters still to be offered, and letter reports still owed by the block.
  char_beat_t char_fifo[$];
  top_rec_t   tops_due[$];

  // Shadow histogram of the sentence in progress.
  logic [CNT_W-1:0] letter_tally [LETTER_COUNT];
  logic [CNT_W-1:0] peak_tally;

  int err_count;
  int chars_in;
  int sentences_in;
  int tops_seen;
  int widest_run;
  int limit_hits;
  int random_chars;

  int  in_gap, in_calm, out_gap, out_calm;
  bit  in_took, out_took;

  initial begin
    clk = 1'b0;
    forever #(CLK_HALF) clk = ~clk;
  end

  // Hold reset low from the start, then release it on a falling edge.
  initial begin
    rst_n = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
  end

  // ---------------------------------------------------------------------------
  // Predictor: count lowercase letters with saturation; on the end mark report
  // every letter at the peak, alphabetically, or a single empty report if the
  // sentence had no letters. Clear the histogram afterwards.
  // ---------------------------------------------------------------------------
  function automatic void tally_char(logic [CHAR_BITS-1:0] ch, logic eos);
    int                        idx;
    int                        last_hit;
    int                        run;
    logic [TOP_COUNT_BITS-1:0] shown;
    top_rec_t                  rec;
    if (ch >= LETTER_FIRST && ch <= LETTER_LAST) begin
      idx = int'(ch - LETTER_FIRST);
      if (letter_tally[idx] != BIN_LIMIT) letter_tally[idx] = letter_tally[idx] + 1'b1;
      if (letter_tally[idx] > peak_tally) peak_tally = letter_tally[idx];
    end
    if (!eos) return;
    sentences_in++;
    if (peak_tally == '0) begin
      rec = '{letter: '0, tally: '0, found: 1'b0, last: 1'b1};
      tops_due.push_back(rec);
      run = 1;
    end else begin
      // Wide bins are clipped to the report field.
      shown = (int'(peak_tally) > int'(TOP_COUNT_MAX)) ? TOP_COUNT_MAX
                                                       : TOP_COUNT_BITS'(peak_tally);
      last_hit = 0;
      run = 0;
      for (int i = 0; i < LETTER_COUNT; i++)
        if (letter_tally[i] == peak_tally) last_hit = i;
      for (int i = 0; i < LETTER_COUNT; i++) begin
        if (letter_tally[i] == peak_tally) begin
          rec.letter = LETTER_BITS'(int'(LETTER_FIRST) + i);
          rec.tally  = shown;
          rec.found  = 1'b1;
          rec.last   = (i == last_hit);
          tops_due.push_back(rec);
          run++;
        end
      end
      if (peak_tally == BIN_LIMIT) limit_hits++;
    end
    if (run > widest_run) widest_run = run;
    for (int i = 0; i < LETTER_COUNT; i++) letter_tally[i] = '0;
    peak_tally = '0;
  endfunction

  // Mostly no gap, sometimes a few cycles, now and then a long one; calm
  // stretches give runs of back-to-back beats.
  function automatic int pick_gap(ref int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 40) == 0) begin
      calm = $urandom_range(20, 80);
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus builders
  // ---------------------------------------------------------------------------
  task automatic add_char(logic [CHAR_BITS-1:0] ch, logic eos, logic hold = 1'b0);
    char_beat_t b;
    b.ch   = ch;
    b.eos  = eos;
    b.hold = hold;
    char_fifo.push_back(b);
  endtask

  // Queue a text as one sentence, the end mark on its final character.
  task automatic add_text(string s, logic hold = 1'b0);
    for (int i = 0; i < s.len(); i++)
      add_char(s[i], i == s.len() - 1, hold && i == 0);
  endtask

  function automatic logic [CHAR_BITS-1:0] any_non_letter();
    logic [CHAR_BITS-1:0] c;
    do c = CHAR_BITS'($urandom_range(0, 255));
    while (c >= LETTER_FIRST && c <= LETTER_LAST);
    return c;
  endfunction

  // One random sentence; most are letter-heavy so that ties and long
  // reports occur, the rest are noise or sentences with no letters.
  task automatic add_random_sentence();
    int                   kind, len, base, span, reps, offs;
    logic [CHAR_BITS-1:0] c;
    logic                 tail_letter;
    kind = $urandom_range(0, 9);
    tail_letter = $urandom_range(0, 1);
    if (kind <= 5) begin
      // mixed text over a random sub-alphabet
      len  = $urandom_range(1, 24);
      span = $urandom_range(1, 26);
      base = $urandom_range(0, LETTER_COUNT - span);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(0, 99) < 70)
          c = LETTER_FIRST + CHAR_BITS'($urandom_range(base, base + span - 1));
        else
          c = CHAR_BITS'($urandom_range(0, 255));
        add_char(c, i == len - 1);
      end
      random_chars += len;
    end else if (kind == 6) begin
      // nothing to count
      len = $urandom_range(1, 6);
      for (int i = 0; i < len; i++) add_char(any_non_letter(), i == len - 1);
      random_chars += len;
    end else if (kind == 7) begin
      // every letter equally often: the longest possible report
      reps = $urandom_range(1, 2);
      offs = $urandom_range(0, LETTER_COUNT - 1);
      len  = reps * LETTER_COUNT;
      for (int i = 0; i < len; i++)
        add_char(LETTER_FIRST + CHAR_BITS'((offs + i) % LETTER_COUNT),
                 !tail_letter && i == len - 1);
      if (tail_letter) add_char(any_non_letter(), 1'b1);
      random_chars += len + int'(tail_letter);
    end else begin
      // narrow alphabet, many ties
      len  = $urandom_range(5, 30);
      base = $urandom_range(0, LETTER_COUNT - 3);
      for (int i = 0; i < len; i++)
        add_char(LETTER_FIRST + CHAR_BITS'($urandom_range(base, base + 2)), i == len - 1);
      random_chars += len;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence: directed cases, a drain, random sentences, one saturating sentence
  // after a second drain, more random sentences, then wait for the tail and report.
  // ---------------------------------------------------------------------------
  initial begin
    in_ch.valid           = 1'b0;
    in_ch.char_code       = '0;
    in_ch.end_of_sentence = 1'b0;
    out_ch.ready          = 1'b0;
    for (int i = 0; i < LETTER_COUNT; i++) letter_tally[i] = '0;
    peak_tally   = '0;
    err_count    = 0;
    chars_in     = 0;
    sentences_in = 0;
    tops_seen    = 0;
    widest_run   = 0;
    limit_hits   = 0;
    random_chars = 0;
    in_gap = 0; in_calm = 0; out_gap = 0; out_calm = 0;
    in_took = 0; out_took = 0;

    // single letter
    add_text("a");
    // bytes just outside the lowercase range, the byte extremes and capitals
    add_char(8'h00, 1'b0);
    add_char(8'hFF, 1'b0);
    add_char(8'h60, 1'b0);
    add_char(8'h7B, 1'b0);
    add_char(8'h41, 1'b0);
    add_char(8'h5A, 1'b1);
    // end mark on punctuation, three-way tie across both ends of the alphabet
    add_text("zab.");
    // end mark on a letter that is counted but does not win
    add_text("zzy");
    // lone end mark with nothing counted
    add_char(8'h80, 1'b1);
    // tie at a count above one, end mark on a non-letter
    add_text("abcbca~");

    // let every directed report arrive before the random part
    while (random_chars < 60) begin
      if (random_chars == 0) char_fifo.push_back('{ch: 8'h20, eos: 1'b0, hold: 1'b1});
      add_random_sentence();
    end

    // drive one bin past the limit so that it saturates; drain first
    add_char("m", 1'b0, 1'b1);
    for (int i = 1; i < int'(BIN_LIMIT) + 2; i++) begin
      add_char("m", 1'b0);
    end
    repeat (3) add_char("q", 1'b0);
    add_char("!", 1'b1);

    while (random_chars < 125) add_random_sentence();

    wait (rst_n === 1'b1);
    while (char_fifo.size() != 0 || in_ch.valid || tops_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYC) @(posedge clk);

    $display("Run covered %0d characters in %0d sentences and %0d letter reports.",
             chars_in, sentences_in, tops_seen);
    $display("Longest report run %0d letters; reports at the bin limit seen %0d time(s).",
             widest_run, limit_hits);
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #(2 * CLK_HALF * 600000);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Input side: note each accepted beat on the rising edge, drive the next
  // one on the falling edge.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) begin
      tally_char(in_ch.char_code, in_ch.end_of_sentence);
      chars_in++;
      in_took = 1'b1;
    end
  end

  always @(negedge clk) begin
    if (rst_n) begin
      // hold a beat that has not yet been taken
      if (!in_ch.valid || in_took) begin
        if (in_gap > 0) begin
          in_ch.valid <= 1'b0;
          in_gap--;
        end else if (char_fifo.size() == 0 ||
                     (char_fifo[0].hold && tops_due.size() != 0)) begin
          // idle, either out of stimulus or draining before a marked beat
          in_ch.valid <= 1'b0;
        end else begin
          in_ch.valid           <= 1'b1;
          in_ch.char_code       <= char_fifo[0].ch;
          in_ch.end_of_sentence <= char_fifo[0].eos;
          void'(char_fifo.pop_front());
          in_gap = pick_gap(in_calm);
        end
      end
      in_took = 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Result side: check each beat against the oldest owed report; stall ready
  // at random on the falling edge.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    top_rec_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      out_took = 1'b1;
      tops_seen++;
      if (tops_due.size() == 0) begin
        $error("unexpected result: top_letter %0d top_count %0d found %0b last_of_run %0b",
               out_ch.top_letter, out_ch.top_count, out_ch.found, out_ch.last_of_run);
        err_count++;
      end else begin
        want = tops_due.pop_front();
        if (out_ch.top_letter !== want.letter) begin
          $error("top_letter: expected %0d, got %0d", want.letter, out_ch.top_letter);
          err_count++;
        end
        if (out_ch.top_count !== want.tally) begin
          $error("top_count: expected %0d, got %0d", want.tally, out_ch.top_count);
          err_count++;
        end
        if (out_ch.found !== want.found) begin
          $error("found: expected %0b, got %0b", want.found, out_ch.found);
          err_count++;
        end
        if (out_ch.last_of_run !== want.last) begin
          $error("last_of_run: expected %0b, got %0b", want.last, out_ch.last_of_run);
          err_count++;
        end
      end
    end
  end

  always @(negedge clk) begin
    if (rst_n) begin
      if (out_gap > 0) begin
        out_ch.ready <= 1'b0;
        out_gap--;
      end else begin
        out_ch.ready <= 1'b1;
        // stall after a taken beat, and now and then out of the blue
        if (out_took || $urandom_range(0, 31) == 0) out_gap = pick_gap(out_calm);
      end
      out_took = 1'b0;
    end
  end

endmodule
